// ----- rtl/dhp_pkg.sv -----
// ----------------------------------------------------------------------------
// dhp_pkg
// Shared constants and result codes for the DER tag-length header parser.
// ----------------------------------------------------------------------------
package dhp_pkg;

	// Largest number of long-form length octets that are decoded
	localparam int unsigned MAX_LEN_OCTETS = 4;

	// Length accumulator width and the width used for the fit compare
	localparam int unsigned ACC_W = 8 * MAX_LEN_OCTETS;
	localparam int unsigned CMP_W = (ACC_W > 32) ? ACC_W : 32;

	// Field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned BLEN_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned HLEN_W   = 8;
	localparam int unsigned VLEN_W   = 32;
	localparam int unsigned LEFT_W   = 7;

	// Reset value of the expected tag register (INTEGER)
	localparam logic [BYTE_W-1:0] TAG_RESET = 8'h02;

	// Result status codes
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_FAIL     = 2'd1;
	localparam status_t STATUS_TOO_MANY = 2'd2;

endpackage

// ----- rtl/dhp_ifs.sv -----
// ----------------------------------------------------------------------------
// dhp_ifs
// Valid/ready channels of the header parser: byte requests, results and
// the expected-tag write channel.
// ----------------------------------------------------------------------------
interface dhp_byte_if import dhp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              start_req;
	logic [BYTE_W-1:0] data_byte;
	logic [BLEN_W-1:0] buffer_len;

	modport source (output valid, start_req, data_byte, buffer_len, input ready);
	modport sink   (input valid, start_req, data_byte, buffer_len, output ready);
	modport mon    (input valid, ready, start_req, data_byte, buffer_len);
endinterface

interface dhp_result_if import dhp_pkg::*; ();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [HLEN_W-1:0] hdr_size;
	logic [VLEN_W-1:0] content_len;

	modport source (output valid, status, hdr_size, content_len, input ready);
	modport sink   (input valid, status, hdr_size, content_len, output ready);
	modport mon    (input valid, ready, status, hdr_size, content_len);
endinterface

interface dhp_cfg_if import dhp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] expected_tag;

	modport source (output valid, expected_tag, input ready);
	modport sink   (input valid, expected_tag, output ready);
	modport mon    (input valid, ready, expected_tag);
endinterface

// ----- rtl/der_header_parser_core.sv -----
// ----------------------------------------------------------------------------
// der_header_parser_core
// Decodes a DER tag-length header presented one byte per request.
// ----------------------------------------------------------------------------
// Usage
//   hdr_byte   : one request per header byte. start_req marks the tag byte,
//                which carries buffer_len, the bytes available in the buffer.
//                A start request abandons any header in progress.
//   hdr_result : at most one result per header: status (ok, parse failed,
//                too many length octets), hdr_size and content_len.
//   cfg        : writes expected_tag; always ready. Write it only while the
//                block is idle.
// Timing
//   A request enters the input register at its handshake and is decoded in
//   the following cycle; the result of the request that completes the header
//   is registered. Requests flow one per cycle unless a result stall holds them;
//   the decode is a single shift-insert, an add, a subtract and 32-bit compares.
// Reset and stalls
//   arst_n clears the decode state to idle, empties both registers and sets
//   expected_tag to 0x02. While a result waits for hdr_result.ready, requests
//   that yield no result keep flowing; one that yields a result is held in
//   the input register until the result register frees up.
// ----------------------------------------------------------------------------
module der_header_parser_core import dhp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	dhp_byte_if.sink     hdr_byte,
	dhp_result_if.source hdr_result,
	dhp_cfg_if.sink      cfg
);

	// Decode phases
	localparam logic [1:0] PH_IDLE       = 2'd0;
	localparam logic [1:0] PH_LEN_BYTE   = 2'd1;
	localparam logic [1:0] PH_LEN_OCTETS = 2'd2;

	// Configuration
	logic [BYTE_W-1:0] tag_q;

	// Input register
	logic              valid_s1;
	logic              start_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [BLEN_W-1:0] blen_s1;

	// Decode state
	logic [1:0]        phase_q;
	logic [LEFT_W-1:0] left_q;
	logic [HLEN_W-1:0] htotal_q;
	logic [ACC_W-1:0]  acc_q;
	logic [BLEN_W-1:0] avail_q;

	// Result register
	logic              res_valid_q;
	status_t           res_status_q;
	logic [HLEN_W-1:0] res_hlen_q;
	logic [VLEN_W-1:0] res_vlen_q;

	// Next-state values
	logic [1:0]        phase_d;
	logic [LEFT_W-1:0] left_d;
	logic [HLEN_W-1:0] htotal_d;
	logic [ACC_W-1:0]  acc_d;
	logic [BLEN_W-1:0] avail_d;
	logic              emit;
	status_t           emit_status;
	logic [HLEN_W-1:0] emit_hlen;
	logic [VLEN_W-1:0] emit_vlen;

	logic              do_finish;
	logic [LEFT_W-1:0] count;
	logic [HLEN_W-1:0] long_htotal;
	logic [BLEN_W-1:0] room;
	logic [CMP_W-1:0]  acc_ext;
	logic [CMP_W-1:0]  room_ext;
	logic              advance;

	assign cfg.ready = 1'b1;

	// Move on when the request needs no result slot, or the slot is free.
	assign advance        = valid_s1 & (~emit | ~res_valid_q | hdr_result.ready);
	assign hdr_byte.ready = ~valid_s1 | advance;

	assign count       = byte_s1[LEFT_W-1:0];
	assign long_htotal = HLEN_W'(2) + HLEN_W'(count);

	// Decode one request against the current state
	always_comb begin
		phase_d     = phase_q;
		left_d      = left_q;
		htotal_d    = htotal_q;
		acc_d       = acc_q;
		avail_d     = avail_q;
		emit        = 1'b0;
		emit_status = STATUS_OK;
		emit_hlen   = '0;
		emit_vlen   = '0;
		do_finish   = 1'b0;

		if (start_s1) begin
			// Tag byte: restart from scratch, check tag and minimum buffer
			avail_d  = blen_s1;
			left_d   = '0;
			htotal_d = '0;
			acc_d    = '0;
			if ((blen_s1 < BLEN_W'(2)) || (byte_s1 != tag_q)) begin
				emit        = 1'b1;
				emit_status = STATUS_FAIL;
				phase_d     = PH_IDLE;
			end else begin
				phase_d = PH_LEN_BYTE;
			end
		end else begin
			case (phase_q)
				PH_LEN_BYTE: begin
					if (!byte_s1[7]) begin
						// Short form: the length sits in the low seven bits
						htotal_d  = HLEN_W'(2);
						acc_d     = ACC_W'(byte_s1[6:0]);
						do_finish = 1'b1;
					end else begin
						htotal_d = long_htotal;
						acc_d    = '0;
						if (BLEN_W'(long_htotal) > avail_q) begin
							emit        = 1'b1;
							emit_status = STATUS_FAIL;
							phase_d     = PH_IDLE;
						end else if (32'(count) > MAX_LEN_OCTETS) begin
							emit        = 1'b1;
							emit_status = STATUS_TOO_MANY;
							emit_hlen   = long_htotal;
							phase_d     = PH_IDLE;
						end else if (count == '0) begin
							do_finish = 1'b1;
						end else begin
							left_d  = count;
							phase_d = PH_LEN_OCTETS;
						end
					end
				end
				PH_LEN_OCTETS: begin
					// Insert the next octet, most significant first
					acc_d  = ACC_W'({acc_q, byte_s1});
					left_d = left_q - LEFT_W'(1);
					if (left_d == '0) begin
						do_finish = 1'b1;
					end
				end
				default: begin
					// Drop stray bytes while idle
				end
			endcase
		end

		// Fit check: header plus value must lie within the buffer
		room     = avail_q - BLEN_W'(htotal_d);
		acc_ext  = CMP_W'(acc_d);
		room_ext = CMP_W'(room);
		if (do_finish) begin
			emit    = 1'b1;
			phase_d = PH_IDLE;
			if (acc_ext > room_ext) begin
				emit_status = STATUS_FAIL;
			end else begin
				emit_status = STATUS_OK;
				emit_hlen   = htotal_d;
				emit_vlen   = acc_ext[VLEN_W-1:0];
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= TAG_RESET;
		end else if (cfg.valid) begin
			tag_q <= cfg.expected_tag;
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr_byte.ready) begin
			valid_s1 <= hdr_byte.valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (hdr_byte.valid && hdr_byte.ready) begin
			start_s1 <= hdr_byte.start_req;
			byte_s1  <= hdr_byte.data_byte;
			blen_s1  <= hdr_byte.buffer_len;
		end
	end

	// Decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			left_q   <= '0;
			htotal_q <= '0;
			acc_q    <= '0;
			avail_q  <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			htotal_q <= htotal_d;
			acc_q    <= acc_d;
			avail_q  <= avail_d;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (hdr_result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_status_q <= emit_status;
			res_hlen_q   <= emit_hlen;
			res_vlen_q   <= emit_vlen;
		end
	end

	assign hdr_result.valid       = res_valid_q;
	assign hdr_result.status      = res_status_q;
	assign hdr_result.hdr_size    = res_hlen_q;
	assign hdr_result.content_len = res_vlen_q;

endmodule

// ----- rtl/dhp_checker.sv -----
// ----------------------------------------------------------------------------
// dhp_checker
// Port-level checks on the header parser results.
// ----------------------------------------------------------------------------
module dhp_checker import dhp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input status_t           res_status,
	input logic [HLEN_W-1:0] res_hdr_size,
	input logic [VLEN_W-1:0] res_content_len
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
			&& $stable(res_hdr_size) && $stable(res_content_len))
		else $error("stalled result changed");

	// A failed parse carries no lengths
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STATUS_FAIL
			|-> res_hdr_size == '0 && res_content_len == '0)
		else $error("failed result carries lengths");

	// Too many length octets: header beyond the supported size, no value
	a_many: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STATUS_TOO_MANY
			|-> 32'(res_hdr_size) > 32'(MAX_LEN_OCTETS + 2) && res_content_len == '0)
		else $error("bad too-many-octets result");

	// A good header is two to two-plus-maximum bytes long
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STATUS_OK
			|-> res_hdr_size >= HLEN_W'(2)
			&& 32'(res_hdr_size) <= 32'(MAX_LEN_OCTETS + 2))
		else $error("bad header length on good result");

	// No unused status code
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_status == STATUS_OK || res_status == STATUS_FAIL
			|| res_status == STATUS_TOO_MANY)
		else $error("unknown status code");

endmodule

bind der_header_parser_core dhp_checker u_dhp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (hdr_result.valid),
	.res_ready       (hdr_result.ready),
	.res_status      (hdr_result.status),
	.res_hdr_size    (hdr_result.hdr_size),
	.res_content_len (hdr_result.content_len)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for der_header_parser_core.
// Drives DER tag-length headers one byte per request, with a short directed
// set followed by randomised headers under three tag settings and varying
// request and result back-pressure. A scoreboard class decodes every
// accepted byte, queues the expected result and checks each returned result
// field by field.
// ----------------------------------------------------------------------------
module tb;
	import dhp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Long-form marker, count mask and the smallest usable buffer
	localparam logic [BYTE_W-1:0] LONG_FORM  = 8'h80;
	localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h7F;
	localparam int unsigned       MIN_BUFFER = 2;

	// Cycles without any handshake before the run is declared hung
	localparam int STALL_LIMIT = 4000;
	// Receiver hold-off used to back the block up
	localparam int HOLD_CYCLES = 400;
	// Header bytes per random phase
	localparam int PHASE_BYTES = 350;

	typedef enum logic [1:0] {
		HDR_IDLE,
		HDR_LEN_BYTE,
		HDR_LEN_OCTETS
	} hdr_phase_t;

	typedef struct packed {
		logic              start;
		logic [BYTE_W-1:0] data;
		logic [BLEN_W-1:0] blen;
	} hdr_req_t;

	typedef struct {
		status_t           status;
		logic [HLEN_W-1:0] hdr_size;
		logic [VLEN_W-1:0] content_len;
	} hdr_result_t;

	// Decodes accepted header bytes and holds the results still to come back
	class header_decode_board;
		hdr_phase_t        phase;
		logic [LEFT_W-1:0] octets_left;
		logic [HLEN_W-1:0] header_total;
		logic [63:0]       length_acc;
		logic [BLEN_W-1:0] avail;
		logic [BYTE_W-1:0] tag;
		hdr_result_t       expected_headers[$];
		int                mismatches;
		int                results_seen;

		function new();
			phase        = HDR_IDLE;
			octets_left  = '0;
			header_total = '0;
			length_acc   = '0;
			avail        = '0;
			tag          = TAG_RESET;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_tag(logic [BYTE_W-1:0] t);
			tag = t;
		endfunction

		function int pending();
			return expected_headers.size();
		endfunction

		function void post(status_t st, logic [HLEN_W-1:0] hl, logic [63:0] vl);
			hdr_result_t r;
			r.status      = st;
			r.hdr_size    = hl;
			r.content_len = vl[VLEN_W-1:0];
			expected_headers.push_back(r);
			phase = HDR_IDLE;
		endfunction

		// Header plus value must fit in the buffer
		function void close_header();
			logic [63:0] room;
			room = {32'b0, avail} - {56'b0, header_total};
			if (length_acc > room)
				post(STATUS_FAIL, '0, '0);
			else
				post(STATUS_OK, header_total, length_acc);
		endfunction

		// Returns 0 when the byte is simply dropped by an idle decoder
		function bit take_byte(hdr_req_t r);
			logic [LEFT_W-1:0] count;
			if (r.start) begin
				avail        = r.blen;
				octets_left  = '0;
				header_total = '0;
				length_acc   = '0;
				if (r.blen < MIN_BUFFER || r.data != tag)
					post(STATUS_FAIL, '0, '0);
				else
					phase = HDR_LEN_BYTE;
				return 1'b1;
			end
			case (phase)
				HDR_LEN_BYTE: begin
					if ((r.data & LONG_FORM) == '0) begin
						header_total = 8'd2;
						length_acc   = {56'b0, r.data};
						close_header();
					end else begin
						count        = LEFT_W'(r.data & COUNT_MASK);
						header_total = HLEN_W'(MIN_BUFFER + count);
						length_acc   = '0;
						if (header_total > avail)
							post(STATUS_FAIL, '0, '0);
						else if (count > MAX_LEN_OCTETS)
							post(STATUS_TOO_MANY, header_total, '0);
						else if (count == '0)
							close_header();
						else begin
							octets_left = count;
							phase       = HDR_LEN_OCTETS;
						end
					end
					return 1'b1;
				end
				HDR_LEN_OCTETS: begin
					length_acc  = (length_acc << 8) | {56'b0, r.data};
					octets_left = octets_left - 1'b1;
					if (octets_left == '0)
						close_header();
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void check_result(hdr_result_t got);
			hdr_result_t want;
			results_seen++;
			if (expected_headers.size() == 0) begin
				$error("unexpected result: status %0d hdr_size %0d content_len %0d",
					got.status, got.hdr_size, got.content_len);
				mismatches++;
				return;
			end
			want = expected_headers.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				mismatches++;
			end
			if (got.hdr_size !== want.hdr_size) begin
				$error("hdr_size: expected %0d, actual %0d",
					want.hdr_size, got.hdr_size);
				mismatches++;
			end
			if (got.content_len !== want.content_len) begin
				$error("content_len: expected 0x%08h, actual 0x%08h",
					want.content_len, got.content_len);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dhp_byte_if   byte_if();
	dhp_result_if res_if();
	dhp_cfg_if    cfg_if();

	der_header_parser_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.hdr_byte   (byte_if),
		.hdr_result (res_if),
		.cfg        (cfg_if)
	);

	header_decode_board board;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_request;
	int bytes_counted;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Known values on every input from time zero
	initial begin
		arst_n                 <= 1'b0;
		byte_if.valid          <= 1'b0;
		byte_if.start_req      <= 1'b0;
		byte_if.data_byte      <= '0;
		byte_if.buffer_len     <= '0;
		cfg_if.valid           <= 1'b0;
		cfg_if.expected_tag    <= '0;
	end

	// Offer one request, after a random gap, and hold it until it is taken
	task automatic send_byte(hdr_req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 40)
			gap++;
		if (gap != 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_if.valid      <= 1'b1;
		byte_if.start_req  <= r.start;
		byte_if.data_byte  <= r.data;
		byte_if.buffer_len <= r.blen;
		do @(posedge clk); while (!byte_if.ready);
		if (board.take_byte(r))
			bytes_counted++;
	endtask

	function automatic hdr_req_t hdr(logic s, logic [BYTE_W-1:0] d, logic [BLEN_W-1:0] b);
		hdr_req_t r;
		r.start = s;
		r.data  = d;
		r.blen  = b;
		return r;
	endfunction

	// Drop valid and let the block drain; a start byte still in flight
	// compares against the tag, so wait on past the last result before
	// anything touches the register
	task automatic settle();
		byte_if.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tag(logic [BYTE_W-1:0] t);
		cfg_if.valid        <= 1'b1;
		cfg_if.expected_tag <= t;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		board.set_tag(t);
	endtask

	// One random header: mostly well formed with random content, some
	// truncated (the next start abandons them) and some pure noise
	task automatic random_header();
		int          pick;
		int          count;
		int          cut;
		int          style;
		logic [63:0] vlen;
		logic [63:0] need;
		logic [7:0]  octet;
		logic [BLEN_W-1:0] blen;
		logic [BYTE_W-1:0] tag_byte;
		hdr_req_t    seq[$];

		pick = $urandom_range(99);
		if (pick < 8) begin
			send_byte(hdr(1'($urandom_range(1)), 8'($urandom), $urandom));
			return;
		end

		tag_byte = ($urandom_range(9) == 0) ? 8'($urandom) : board.tag;
		pick = $urandom_range(99);
		if (pick < 40)
			count = -1;
		else if (pick < 85)
			count = $urandom_range(MAX_LEN_OCTETS, 0);
		else
			count = $urandom_range(127, MAX_LEN_OCTETS + 1);

		vlen = '0;
		if (count < 0) begin
			vlen = 64'($urandom_range(127));
			need = vlen + 2;
		end else if (count <= MAX_LEN_OCTETS) begin
			for (int i = 0; i < count; i++) begin
				// Keep leading octets zero now and then, so values fit often
				octet = (i < count - 2 && $urandom_range(1) == 1) ? 8'h00 : 8'($urandom);
				vlen  = (vlen << 8) | {56'b0, octet};
			end
			need = vlen + 2 + count;
		end else
			need = 64'(2 + count);

		style = $urandom_range(9);
		if (need > 64'hFFFF_FFFF || style == 0)
			blen = $urandom;
		else if (style == 1)
			blen = BLEN_W'($urandom_range(3));
		else if (style == 2)
			blen = BLEN_W'(need - 1);
		else if (style == 3 && need < 64'hFFFF_0000)
			blen = BLEN_W'(need + $urandom_range(1000, 1));
		else
			blen = BLEN_W'(need);

		seq.push_back(hdr(1'b1, tag_byte, blen));
		if (count < 0)
			seq.push_back(hdr(1'b0, vlen[7:0], $urandom));
		else begin
			seq.push_back(hdr(1'b0, LONG_FORM | 8'(count), $urandom));
			if (count <= MAX_LEN_OCTETS)
				for (int i = count - 1; i >= 0; i--)
					seq.push_back(hdr(1'b0, vlen[8*i +: 8], $urandom));
		end

		if ($urandom_range(99) < 8 && seq.size() > 1) begin
			cut = $urandom_range(seq.size() - 1, 1);
			while (seq.size() > cut)
				void'(seq.pop_back());
		end

		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic random_phase(int n);
		int target;
		target = bytes_counted + n;
		while (bytes_counted < target)
			random_header();
	endtask

	// Result side: check every accepted result, then pick ready for the
	// next cycle; a hold-off request from the main thread is counted here
	initial begin
		hdr_result_t got;
		int          hold;
		bit          hold_taken;
		hold       = 0;
		hold_taken = 1'b0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready) begin
				got.status      = res_if.status;
				got.hdr_size    = res_if.hdr_size;
				got.content_len = res_if.content_len;
				board.check_result(got);
			end
			if (hold_request != 0 && !hold_taken) begin
				hold       = hold_request;
				hold_taken = 1'b1;
			end
			if (hold != 0) begin
				hold--;
				res_if.ready <= 1'b0;
			end else
				res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: any handshake resets the count of quiet cycles
	always @(posedge clk) begin
		if (!arst_n || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		board         = new();
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		hold_request  = 0;
		bytes_counted = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed headers under the reset tag
		send_byte(hdr(1'b1, TAG_RESET, 32'd0));              // buffer too short
		send_byte(hdr(1'b1, 8'hFF, 32'hFFFF_FFFF));          // tag mismatch
		send_byte(hdr(1'b1, TAG_RESET, 32'd10));             // abandoned below
		send_byte(hdr(1'b0, 8'h82, 32'd0));
		send_byte(hdr(1'b0, 8'h01, 32'd0));
		send_byte(hdr(1'b1, TAG_RESET, 32'd2));              // short form, empty value
		send_byte(hdr(1'b0, 8'h00, 32'd0));
		send_byte(hdr(1'b1, TAG_RESET, 32'd128));            // value overruns by one
		send_byte(hdr(1'b0, 8'h7F, 32'hFFFF_FFFF));
		send_byte(hdr(1'b0, 8'h55, 32'hFFFF_FFFF));          // dropped while idle
		send_byte(hdr(1'b1, TAG_RESET, 32'd2));              // long form, no octets
		send_byte(hdr(1'b0, LONG_FORM, 32'd0));
		send_byte(hdr(1'b1, TAG_RESET, 32'hFFFF_FFFF));      // widest length, exact fit
		send_byte(hdr(1'b0, 8'h84, 32'd0));
		send_byte(hdr(1'b0, 8'hFF, 32'd0));
		send_byte(hdr(1'b0, 8'hFF, 32'd0));
		send_byte(hdr(1'b0, 8'hFF, 32'd0));
		send_byte(hdr(1'b0, 8'hF9, 32'd0));
		send_byte(hdr(1'b1, TAG_RESET, 32'hFFFF_FFFF));      // too many octets, 127
		send_byte(hdr(1'b0, 8'hFF, 32'd0));
		send_byte(hdr(1'b1, TAG_RESET, 32'd3));              // octets beyond buffer
		send_byte(hdr(1'b0, 8'h82, 32'd0));
		send_byte(hdr(1'b1, TAG_RESET, 32'd8));              // non-minimal long form
		send_byte(hdr(1'b0, 8'h81, 32'd0));
		send_byte(hdr(1'b0, 8'h05, 32'd0));
		settle();

		// Busy sender, lazy receiver; back the block up with a long hold
		write_tag(8'h00);
		tx_idle_pct  = 35;
		rx_idle_pct  = 80;
		hold_request = HOLD_CYCLES;
		random_phase(PHASE_BYTES);
		settle();

		// Lazy sender, busy receiver
		write_tag(8'hFF);
		tx_idle_pct = 80;
		rx_idle_pct = 35;
		random_phase(PHASE_BYTES);
		settle();

		// Full rate both ways
		write_tag(8'($urandom_range(255)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(PHASE_BYTES);
		settle();

		repeat (8) @(posedge clk);

		$display("Decoded %0d header bytes under four tag values, %0d results checked,",
			bytes_counted, board.results_seen);
		$display("with idle gaps on both channels and a long result stall.");
		if (board.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
